FILE: rtl/sgdru_pkg.sv
// ----------------------------------------------------------------------------
// sgdru_pkg
// Shared types and constants of the regression update block: control
// bundles between the sequencer, the lanes and the merge stage, register
// addresses and operation codes.
// ----------------------------------------------------------------------------
package sgdru_pkg;

  localparam int FIELD_BITS = 32;
  localparam int SLOTS      = 8;
  localparam int FRAC_BITS  = 5;
  localparam int RATE_BITS  = 31;
  localparam int ADDR_BITS  = 4;

  // Register map
  localparam logic [ADDR_BITS-1:0] ADDR_FRAC_BITS = 4'h0;
  localparam logic [ADDR_BITS-1:0] ADDR_LRATE     = 4'h4;
  localparam logic [ADDR_BITS-1:0] ADDR_MODE      = 4'h8;

  localparam logic [FRAC_BITS-1:0] FRAC_RESET  = 5'd12;
  localparam logic [RATE_BITS-1:0] LRATE_RESET = 31'd40;

  localparam logic MODE_LINEAR   = 1'b0;
  localparam logic MODE_LOGISTIC = 1'b1;

  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Operand selection of the lane multiplier
  typedef enum logic [1:0] {
    MUL_DOT  = 2'b00,  // feature times weight
    MUL_GRAD = 2'b01,  // error times feature
    MUL_STEP = 2'b10   // learning rate times gradient term
  } mul_sel_t;

  typedef struct packed {
    logic     load_x;
    logic     load_w;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     shift_en;
    logic     update_en;
  } lane_ctl_t;

  typedef struct packed {
    logic load_label;
    logic sum_en;
    logic act_en;
    logic err_en;
  } merge_ctl_t;

endpackage

FILE: rtl/sgdru_lane.sv
// ----------------------------------------------------------------------------
// sgdru_lane
// One weight lane: holds a weight and the current feature, and runs the
// shared multiply and truncating shift for the dot product, the gradient
// and the step.
// ----------------------------------------------------------------------------
module sgdru_lane #(
  parameter int W = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sgdru_pkg::lane_ctl_t                ctl,
  input  logic [sgdru_pkg::FRAC_BITS-1:0]     frac_bits,
  input  logic [sgdru_pkg::FIELD_BITS-1:0]    feature,
  input  logic signed [W-1:0]                 err,
  input  logic signed [W-1:0]                 alpha,
  output logic signed [W-1:0]                 term,
  output logic signed [W-1:0]                 weight
);
  import sgdru_pkg::*;

  logic signed [W-1:0]   x;
  logic signed [2*W-1:0] prod;
  logic signed [W-1:0]   op_a;
  logic signed [W-1:0]   op_b;
  logic        [2*W:0]   bias;
  logic signed [2*W:0]   biased;
  logic signed [2*W:0]   shifted;

  always_comb begin
    case (ctl.mul_sel)
      MUL_DOT: begin
        op_a = x;
        op_b = weight;
      end
      MUL_GRAD: begin
        op_a = err;
        op_b = x;
      end
      MUL_STEP: begin
        op_a = alpha;
        op_b = term;
      end
      default: begin
        op_a = x;
        op_b = weight;
      end
    endcase
  end

  // Adding 2^f - 1 to a negative product makes the arithmetic shift round
  // toward zero instead of toward minus infinity.
  always_comb begin
    bias    = prod[2*W-1] ? ~({(2*W+1){1'b1}} << frac_bits) : '0;
    biased  = (2*W+1)'(prod) + signed'(bias);
    shifted = biased >>> frac_bits;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_x) begin
      x <= feature[W-1:0];
    end
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
    if (ctl.shift_en) begin
      term <= shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctl.load_w) begin
      weight <= feature[W-1:0];
    end else if (ctl.update_en) begin
      weight <= weight - term;
    end
  end

endmodule

FILE: rtl/sgdru_merge.sv
// ----------------------------------------------------------------------------
// sgdru_merge
// Merge stage: sums the lane terms into the prediction, applies the
// optional piecewise-linear sigmoid and forms the error against the label.
// ----------------------------------------------------------------------------
module sgdru_merge #(
  parameter int W        = 32,
  parameter int FEATURES = 8
) (
  input  logic                              clk,
  input  sgdru_pkg::merge_ctl_t             ctl,
  input  logic [sgdru_pkg::FRAC_BITS-1:0]   frac_bits,
  input  logic                              mode,
  input  logic [sgdru_pkg::FIELD_BITS-1:0]  label_in,
  input  logic [FEATURES-1:0][W-1:0]        terms,
  output logic signed [W-1:0]               err
);
  import sgdru_pkg::*;

  localparam int SW = 36;  // holds 4 * 2^31 with sign

  logic signed [W-1:0]  label;
  logic signed [W-1:0]  sum;
  logic signed [W-1:0]  act;
  logic        [W-1:0]  tree;
  logic signed [SW-1:0] u_ext;
  logic signed [SW-1:0] four;
  logic signed [SW-1:0] one_v;
  logic signed [SW-1:0] mid;
  logic signed [W-1:0]  sig;

  always_comb begin
    tree = '0;
    for (int i = 0; i < FEATURES; i++) begin
      tree = tree + terms[i];
    end
  end

  always_comb begin
    u_ext = SW'(sum);
    four  = SW'(4) <<< frac_bits;
    one_v = SW'(1) <<< frac_bits;
    mid   = (u_ext + four) >>> 3;
    if (u_ext < -four) begin
      sig = '0;
    end else if (u_ext > four) begin
      sig = one_v[W-1:0];
    end else begin
      sig = mid[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_label) begin
      label <= label_in[W-1:0];
    end
    if (ctl.sum_en) begin
      sum <= tree;
    end
    if (ctl.act_en) begin
      act <= (mode == MODE_LOGISTIC) ? sig : sum;
    end
    if (ctl.err_en) begin
      err <= act - label;
    end
  end

endmodule

FILE: rtl/sgd_regression_update.sv
// ----------------------------------------------------------------------------
// sgd_regression_update
// A train beat runs the step sequence below before its result is shown; a load
// beat goes straight to the result step. A new beat is taken only once the
// previous one is written to the output register, and a waiting result holds
// the result step.
// The sequencer walks the lanes through three dependent multiplies, each a
// multiply step and a shift step, plus sum, activation (sigmoid in logistic
// mode), error and update steps. Reset (rst, synchronous) clears the weights,
// the sequencer and the output valid, and returns the registers to frac_bits
// 12, rate 40, logistic mode.
module sgd_regression_update #(
  parameter int FEATURES  = 8,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata from bit 0 up: feature_0 .. feature_7, label (32 bits each)
  input  logic [9*sgdru_pkg::FIELD_BITS-1:0] s_tdata,
  // s_tuser: operation (0 train, 1 load weights)
  input  logic                               s_tuser,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata from bit 0 up: weight_0 .. weight_7 (32 bits each)
  output logic [8*sgdru_pkg::FIELD_BITS-1:0] m_tdata,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sgdru_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sgdru_pkg::*;

  // One-hot sequencer states, one per step of a train beat.
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_MUL1 = 12'b0000_0000_0010,
    ST_SHF1 = 12'b0000_0000_0100,
    ST_SUM  = 12'b0000_0000_1000,
    ST_ACT  = 12'b0000_0001_0000,
    ST_ERR  = 12'b0000_0010_0000,
    ST_MUL2 = 12'b0000_0100_0000,
    ST_SHF2 = 12'b0000_1000_0000,
    ST_MUL3 = 12'b0001_0000_0000,
    ST_SHF3 = 12'b0010_0000_0000,
    ST_UPD  = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [FRAC_BITS-1:0] frac_bits;
  logic [RATE_BITS-1:0] step_size;
  logic                 mode;

  logic                 in_accept;
  logic                 cfg_write;
  logic                 out_load;

  lane_ctl_t            lane_ctl;
  merge_ctl_t           merge_ctl;

  logic [31:0]                    rate_ext;
  logic signed [WORD_BITS-1:0]    alpha;
  logic signed [WORD_BITS-1:0]    err;
  logic [FEATURES-1:0][WORD_BITS-1:0] terms;
  logic [FEATURES-1:0][WORD_BITS-1:0] weights;
  logic [SLOTS-1:0][FIELD_BITS-1:0]   result;

  // --------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes
  // in its access cycle. Writes to addresses outside the map are dropped.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= FRAC_RESET;
      step_size <= LRATE_RESET;
      mode      <= MODE_LOGISTIC;
    end else if (cfg_write) begin
      case (paddr)
        ADDR_FRAC_BITS: frac_bits <= pwdata[FRAC_BITS-1:0];
        ADDR_LRATE:     step_size <= pwdata[RATE_BITS-1:0];
        ADDR_MODE:      mode      <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_FRAC_BITS: prdata = 32'(frac_bits);
      ADDR_LRATE:     prdata = 32'(step_size);
      ADDR_MODE:      prdata = 32'(mode);
      default:        prdata = '0;
    endcase
  end

  // The learning rate is taken as a signed word of the datapath width.
  assign rate_ext = 32'(step_size);
  assign alpha    = rate_ext[WORD_BITS-1:0];

  // --------------------------------------------------------------------------
  // Sequencer. A beat is taken only in idle; the output register decouples
  // the result side, so a new beat may be accepted while a result waits.
  // --------------------------------------------------------------------------
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid & s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (s_tuser == OP_LOAD) ? ST_DONE : ST_MUL1;
        end
      end
      ST_MUL1: state_next = ST_SHF1;
      ST_SHF1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_ACT;
      ST_ACT:  state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SHF2;
      ST_SHF2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_SHF3;
      ST_SHF3: state_next = ST_UPD;
      ST_UPD:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lane and merge controls decoded from the state.
  always_comb begin
    lane_ctl.load_x    = in_accept;
    lane_ctl.load_w    = in_accept && (s_tuser == OP_LOAD);
    lane_ctl.mul_en    = (state == ST_MUL1) || (state == ST_MUL2) || (state == ST_MUL3);
    lane_ctl.shift_en  = (state == ST_SHF1) || (state == ST_SHF2) || (state == ST_SHF3);
    lane_ctl.update_en = (state == ST_UPD);
    if (state == ST_MUL2) begin
      lane_ctl.mul_sel = MUL_GRAD;
    end else if (state == ST_MUL3) begin
      lane_ctl.mul_sel = MUL_STEP;
    end else begin
      lane_ctl.mul_sel = MUL_DOT;
    end
    merge_ctl.load_label = in_accept;
    merge_ctl.sum_en     = (state == ST_SUM);
    merge_ctl.act_en     = (state == ST_ACT);
    merge_ctl.err_en     = (state == ST_ERR);
  end

  // --------------------------------------------------------------------------
  // Lanes: one per feature, each with its own weight and multiplier.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < FEATURES; i++) begin : g_lane
    sgdru_lane #(
      .W (WORD_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl),
      .frac_bits (frac_bits),
      .feature   (s_tdata[i*FIELD_BITS +: FIELD_BITS]),
      .err       (err),
      .alpha     (alpha),
      .term      (terms[i]),
      .weight    (weights[i])
    );
  end

  sgdru_merge #(
    .W        (WORD_BITS),
    .FEATURES (FEATURES)
  ) u_merge (
    .clk       (clk),
    .ctl       (merge_ctl),
    .frac_bits (frac_bits),
    .mode      (mode),
    .label_in  (s_tdata[SLOTS*FIELD_BITS +: FIELD_BITS]),
    .terms     (terms),
    .err       (err)
  );

  // --------------------------------------------------------------------------
  // Result beat: weights sign-extended to 32 bits, unused slots read zero.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      result[i] = '0;
      if (i < FEATURES) begin
        result[i] = FIELD_BITS'(signed'(weights[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // A load beat goes straight to the result step.
  a_load_to_done: assert property (@(posedge clk) disable iff (rst)
    in_accept && (s_tuser == OP_LOAD) |=> state == ST_DONE)
    else $error("load beat did not go to the result step");

  // A train beat starts with the dot-product multiply.
  a_train_to_mul: assert property (@(posedge clk) disable iff (rst)
    in_accept && (s_tuser == OP_TRAIN) |=> state == ST_MUL1)
    else $error("train beat did not start the dot product");

  // A new result appears only after the result step.
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result valid raised outside the result step");

  // Weights move only on a load or on the update step.
  a_weights_hold: assert property (@(posedge clk) disable iff (rst)
    !lane_ctl.load_w && !lane_ctl.update_en |=> $stable(weights))
    else $error("weights changed without load or update");
`endif

endmodule
